[design/nested_region_profiler_macros.svh]
// Assertion macros used by the profiler checker.
`ifndef NESTED_REGION_PROFILER_MACROS_SVH
`define NESTED_REGION_PROFILER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define NRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/nrp_pkg.sv]
// Types, codes and helper functions of the nested region profiler.
package nrp_pkg;

  localparam int NUM_REGIONS_DEF     = 7;
  localparam int NUM_RECORDS_DEF     = 32;
  localparam int STACK_DEPTH_DEF     = 8;
  localparam int CALLBACK_REGION_DEF = 5;

  // internal counter and compare width, holds every index and count up to 511
  localparam int CNT_W = 9;

  localparam logic [1:0] STS_DONE = 2'd0;
  localparam logic [1:0] STS_IGN  = 2'd1;
  localparam logic [1:0] STS_UNM  = 2'd2;
  localparam logic [1:0] STS_DROP = 2'd3;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_STAMP     = 3'd0,
    ACT_CALLBACK  = 3'd1,
    ACT_PAUSE     = 3'd2,
    ACT_RESUME    = 3'd3,
    ACT_CLEAR     = 3'd4,
    ACT_RD_REGION = 3'd5,
    ACT_RD_RECORD = 3'd6,
    ACT_RD_TOTALS = 3'd7
  } act_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_STAMP_UPD, S_POP_RD, S_POP_REC, S_POP_WR,
    S_CB_UPD, S_SCAN, S_SCAN_CMP,
    S_PS_RG_RD, S_PS_RG_WR, S_PS_STK, S_PS_REC, S_PS_WR,
    S_RS_RG_RD, S_RS_RG_WR, S_RS_STK,
    S_RR, S_RC, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    C_NONE, C_CAP, C_FIN_IGN,
    C_RG_RD_ID, C_STAMP_WR,
    C_POP_RD, C_REC_RD_STK, C_REC_ADD_WR,
    C_RG_RD_CB, C_RG_ENTER_WR,
    C_REC_RD_CNT, C_CNT_INC, C_CB_DROP, C_CB_NEW, C_CB_HIT,
    C_PAUSE_ACT, C_RG_RD_CNT, C_RG_SUM_WR, C_STK_RD_CNT, C_PAUSE_END,
    C_RESUME_ACT, C_RG_START_WR, C_STK_START_WR,
    C_CLEAR,
    C_RG_RD_IDX, C_RES_REGION, C_REC_RD_IDX, C_RES_RECORD, C_RES_TOTALS,
    C_OUT_LOAD
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic running;
    logic id_ok;
    logic cb_ok;
    logic idx_rg_ok;
    logic idx_rec_ok;
    logic pop_need;
    logic scan_end;
    logic match;
    logic fill_full;
    logic rg_last;
    logic stk_end;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [15:0] depth;
    logic [31:0] start;
    logic [47:0] sum;
    logic [31:0] unm;
  } rg_ent_t;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] calls;
    logic [47:0] sum;
  } rec_ent_t;

  function automatic logic [31:0] inc32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add48(input logic [47:0] sum, input logic [31:0] now,
                                        input logic [31:0] start);
    logic [48:0] s;
    s = {1'b0, sum} + {17'd0, now - start};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic rg_ent_t rg_enter(input rg_ent_t e, input logic [31:0] now);
    rg_ent_t r;
    r = e;
    r.calls = inc32(e.calls);
    if (e.depth == 16'd0) r.start = now;
    if (e.depth != 16'hFFFF) r.depth = e.depth + 16'd1;
    return r;
  endfunction

endpackage

[design/nested_region_profiler.sv]
// Nested region profiler top level: sequencer plus datapath.
// One item at a time; the result of a callback enter follows a record table scan,
// and pause and resume each walk all NUM_REGIONS region entries and then the stack.
// The next item is taken the cycle after the result is loaded, never before that.
// rst_ni (async, low) empties all counters, tables and the stack; no clearing pass.
module nested_region_profiler #(
  parameter int NUM_REGIONS     = nrp_pkg::NUM_REGIONS_DEF,
  parameter int NUM_RECORDS     = nrp_pkg::NUM_RECORDS_DEF,
  parameter int STACK_DEPTH     = nrp_pkg::STACK_DEPTH_DEF,
  parameter int CALLBACK_REGION = nrp_pkg::CALLBACK_REGION_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  region_id_i,
  input  logic        is_exit_i,
  input  logic [31:0] call_pc_i,
  input  logic [31:0] now_ticks_i,
  input  logic [4:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  record_index_o,
  output logic [31:0] call_count_o,
  output logic [15:0] open_depth_o,
  output logic [31:0] unmatched_count_o,
  output logic [47:0] total_ticks_o,
  output logic [31:0] record_pc_o,
  output logic [5:0]  records_used_o,
  output logic [31:0] drop_count_o,
  output logic        is_running_o
);
  import nrp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  nrp_dpath #(
    .NUM_REGIONS     (NUM_REGIONS),
    .NUM_RECORDS     (NUM_RECORDS),
    .STACK_DEPTH     (STACK_DEPTH),
    .CALLBACK_REGION (CALLBACK_REGION)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .region_id_i       (region_id_i),
    .is_exit_i         (is_exit_i),
    .call_pc_i         (call_pc_i),
    .now_ticks_i       (now_ticks_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .record_index_o    (record_index_o),
    .call_count_o      (call_count_o),
    .open_depth_o      (open_depth_o),
    .unmatched_count_o (unmatched_count_o),
    .total_ticks_o     (total_ticks_o),
    .record_pc_o       (record_pc_o),
    .records_used_o    (records_used_o),
    .drop_count_o      (drop_count_o),
    .is_running_o      (is_running_o)
  );

endmodule

[design/nrp_ctrl.sv]
// Sequencer of the profiler: walks each action through its datapath steps.
module nrp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  nrp_pkg::sts_t sts_i,
  output nrp_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);
  import nrp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = C_NONE;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = C_CAP;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.act)
          ACT_STAMP: begin
            if (!sts_i.running || !sts_i.id_ok) begin
              cmd_o.op = C_FIN_IGN;
              state_d  = S_OUT;
            end else begin
              cmd_o.op = C_RG_RD_ID;
              state_d  = S_STAMP_UPD;
            end
          end
          ACT_CALLBACK: begin
            if (!sts_i.running) begin
              cmd_o.op = C_FIN_IGN;
              state_d  = S_OUT;
            end else if (sts_i.cb_ok) begin
              cmd_o.op = C_RG_RD_CB;
              state_d  = S_CB_UPD;
            end else begin
              state_d = S_SCAN;
            end
          end
          ACT_PAUSE: begin
            if (!sts_i.running) begin
              cmd_o.op = C_FIN_IGN;
              state_d  = S_OUT;
            end else begin
              cmd_o.op = C_PAUSE_ACT;
              state_d  = S_PS_RG_RD;
            end
          end
          ACT_RESUME: begin
            if (sts_i.running) begin
              cmd_o.op = C_FIN_IGN;
              state_d  = S_OUT;
            end else begin
              cmd_o.op = C_RESUME_ACT;
              state_d  = S_RS_RG_RD;
            end
          end
          ACT_CLEAR: begin
            cmd_o.op = C_CLEAR;
            state_d  = S_OUT;
          end
          ACT_RD_REGION: begin
            if (!sts_i.idx_rg_ok) begin
              cmd_o.op = C_FIN_IGN;
              state_d  = S_OUT;
            end else begin
              cmd_o.op = C_RG_RD_IDX;
              state_d  = S_RR;
            end
          end
          ACT_RD_RECORD: begin
            if (!sts_i.idx_rec_ok) begin
              cmd_o.op = C_FIN_IGN;
              state_d  = S_OUT;
            end else begin
              cmd_o.op = C_REC_RD_IDX;
              state_d  = S_RC;
            end
          end
          default: begin
            cmd_o.op = C_RES_TOTALS;
            state_d  = S_OUT;
          end
        endcase
      end
      S_STAMP_UPD: begin
        cmd_o.op = C_STAMP_WR;
        state_d  = sts_i.pop_need ? S_POP_RD : S_OUT;
      end
      S_POP_RD: begin
        cmd_o.op = C_POP_RD;
        state_d  = S_POP_REC;
      end
      S_POP_REC: begin
        cmd_o.op = C_REC_RD_STK;
        state_d  = S_POP_WR;
      end
      S_POP_WR: begin
        cmd_o.op = C_REC_ADD_WR;
        state_d  = S_OUT;
      end
      S_CB_UPD: begin
        cmd_o.op = C_RG_ENTER_WR;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          cmd_o.op = sts_i.fill_full ? C_CB_DROP : C_CB_NEW;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = C_REC_RD_CNT;
          state_d  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.op = C_CB_HIT;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = C_CNT_INC;
          state_d  = S_SCAN;
        end
      end
      S_PS_RG_RD: begin
        cmd_o.op = C_RG_RD_CNT;
        state_d  = S_PS_RG_WR;
      end
      S_PS_RG_WR: begin
        cmd_o.op = C_RG_SUM_WR;
        state_d  = sts_i.rg_last ? S_PS_STK : S_PS_RG_RD;
      end
      S_PS_STK: begin
        if (sts_i.stk_end) begin
          cmd_o.op = C_PAUSE_END;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = C_STK_RD_CNT;
          state_d  = S_PS_REC;
        end
      end
      S_PS_REC: begin
        cmd_o.op = C_REC_RD_STK;
        state_d  = S_PS_WR;
      end
      S_PS_WR: begin
        cmd_o.op = C_REC_ADD_WR;
        state_d  = S_PS_STK;
      end
      S_RS_RG_RD: begin
        cmd_o.op = C_RG_RD_CNT;
        state_d  = S_RS_RG_WR;
      end
      S_RS_RG_WR: begin
        cmd_o.op = C_RG_START_WR;
        state_d  = sts_i.rg_last ? S_RS_STK : S_RS_RG_RD;
      end
      S_RS_STK: begin
        if (sts_i.stk_end) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = C_STK_START_WR;
        end
      end
      S_RR: begin
        cmd_o.op = C_RES_REGION;
        state_d  = S_OUT;
      end
      S_RC: begin
        cmd_o.op = C_RES_RECORD;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = C_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/nrp_dpath.sv]
// Datapath of the profiler: counters, region/record/stack stores and result register.
module nrp_dpath #(
  parameter int NUM_REGIONS     = nrp_pkg::NUM_REGIONS_DEF,
  parameter int NUM_RECORDS     = nrp_pkg::NUM_RECORDS_DEF,
  parameter int STACK_DEPTH     = nrp_pkg::STACK_DEPTH_DEF,
  parameter int CALLBACK_REGION = nrp_pkg::CALLBACK_REGION_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nrp_pkg::cmd_t cmd_i,
  output nrp_pkg::sts_t sts_o,
  input  logic [2:0]    action_i,
  input  logic [7:0]    region_id_i,
  input  logic          is_exit_i,
  input  logic [31:0]   call_pc_i,
  input  logic [31:0]   now_ticks_i,
  input  logic [4:0]    read_index_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    status_o,
  output logic [4:0]    record_index_o,
  output logic [31:0]   call_count_o,
  output logic [15:0]   open_depth_o,
  output logic [31:0]   unmatched_count_o,
  output logic [47:0]   total_ticks_o,
  output logic [31:0]   record_pc_o,
  output logic [5:0]    records_used_o,
  output logic [31:0]   drop_count_o,
  output logic          is_running_o
);
  import nrp_pkg::*;

  localparam int RW = $clog2(NUM_REGIONS);
  localparam int CW = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
  localparam int FW = $clog2(NUM_RECORDS + 1);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TW = $clog2(STACK_DEPTH + 1);
  localparam logic CB_OK = (CALLBACK_REGION < NUM_REGIONS);
  localparam logic [CNT_W-1:0] CB_ID = CNT_W'(CALLBACK_REGION);

  // latched item
  act_e        act_q;
  logic [7:0]  id_q;
  logic        exit_q;
  logic [31:0] pc_q, now_q;
  logic [4:0]  idx_q;

  // control state
  logic          running_q;
  logic [31:0]   act_start_q;
  logic [47:0]   act_sum_q;
  logic [NUM_REGIONS-1:0] rg_vld_q;
  logic [FW-1:0] fill_q;
  logic [TW-1:0] top_q;
  logic [31:0]   drops_q;
  logic [CNT_W-1:0] cnt_q;
  logic          out_valid_q;

  // stores
  rg_ent_t  rg_mem  [NUM_REGIONS];
  rec_ent_t rec_mem [NUM_RECORDS];
  logic [CW-1:0] stk_rec_mem   [STACK_DEPTH];
  logic [31:0]   stk_start_mem [STACK_DEPTH];

  rg_ent_t       rg_rd_q;
  logic          rg_rvld_q;
  logic [RW-1:0] rg_addr_q;
  rec_ent_t      rec_rd_q;
  logic [CW-1:0] rec_addr_q;
  logic [CW-1:0] stk_rec_rd_q;
  logic [31:0]   stk_start_rd_q;

  // result being built
  logic [1:0]  res_status_q;
  logic [4:0]  res_idx_q;
  logic [31:0] res_calls_q, res_unm_q, res_pc_q;
  logic [15:0] res_depth_q;
  logic [47:0] res_sum_q;

  logic [CNT_W-1:0] id9, idx9, fill9, top9, top_m1;
  rg_ent_t       rg_e, rg_wd;
  logic          rg_re, rg_we;
  logic [RW-1:0] rg_ra;
  rec_ent_t      rec_wd;
  logic          rec_re, rec_we;
  logic [CW-1:0] rec_ra, rec_wa;
  logic          stk_re, push, stk_we, stk_start_we;
  logic [SW-1:0] stk_ra, stk_wa;
  logic [31:0]   stk_wstart;
  logic [CW-1:0] push_idx;
  logic          top_full, accept_out;

  assign id9      = CNT_W'(id_q);
  assign idx9     = CNT_W'(idx_q);
  assign fill9    = CNT_W'(fill_q);
  assign top9     = CNT_W'(top_q);
  assign top_m1   = top9 - CNT_W'(1);
  assign rg_e     = rg_rvld_q ? rg_rd_q : '0;
  assign top_full = (top_q == TW'(STACK_DEPTH));
  assign accept_out = out_valid_q && !out_stall_i;

  always_comb begin
    sts_o.act        = act_q;
    sts_o.running    = running_q;
    sts_o.id_ok      = (id9 != '0) && (id9 < CNT_W'(NUM_REGIONS));
    sts_o.cb_ok      = CB_OK;
    sts_o.idx_rg_ok  = (idx9 != '0) && (idx9 < CNT_W'(NUM_REGIONS));
    sts_o.idx_rec_ok = (idx9 < fill9);
    sts_o.pop_need   = exit_q && (rg_e.depth != 16'd0) && (id9 == CB_ID) && (top_q != '0);
    sts_o.scan_end   = (cnt_q == fill9);
    sts_o.match      = (rec_rd_q.pc == pc_q);
    sts_o.fill_full  = (fill_q == FW'(NUM_RECORDS));
    sts_o.rg_last    = (cnt_q == CNT_W'(NUM_REGIONS - 1));
    sts_o.stk_end    = (cnt_q == top9);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // store port control
  always_comb begin
    rg_re = 1'b0; rg_ra = '0; rg_we = 1'b0; rg_wd = rg_e;
    rec_re = 1'b0; rec_ra = '0; rec_we = 1'b0; rec_wa = rec_addr_q; rec_wd = rec_rd_q;
    stk_re = 1'b0; stk_ra = '0; push = 1'b0; push_idx = '0;
    stk_start_we = 1'b0; stk_wa = top9[SW-1:0]; stk_wstart = now_q;
    case (cmd_i.op)
      C_RG_RD_ID: begin
        rg_re = 1'b1; rg_ra = id9[RW-1:0];
      end
      C_RG_RD_CB: begin
        rg_re = 1'b1; rg_ra = CB_ID[RW-1:0];
      end
      C_RG_RD_CNT: begin
        rg_re = 1'b1; rg_ra = cnt_q[RW-1:0];
      end
      C_RG_RD_IDX: begin
        rg_re = 1'b1; rg_ra = idx9[RW-1:0];
      end
      C_STAMP_WR: begin
        rg_we = 1'b1;
        if (!exit_q) begin
          rg_wd = rg_enter(rg_e, now_q);
        end else if (rg_e.depth == 16'd0) begin
          rg_wd.unm = inc32(rg_e.unm);
        end else begin
          rg_wd.depth = rg_e.depth - 16'd1;
          if (rg_e.depth == 16'd1) rg_wd.sum = add48(rg_e.sum, now_q, rg_e.start);
        end
      end
      C_RG_ENTER_WR: begin
        rg_we = 1'b1; rg_wd = rg_enter(rg_e, now_q);
      end
      C_RG_SUM_WR: begin
        rg_we = (rg_e.depth != 16'd0);
        rg_wd.sum = add48(rg_e.sum, now_q, rg_e.start);
      end
      C_RG_START_WR: begin
        rg_we = (rg_e.depth != 16'd0);
        rg_wd.start = now_q;
      end
      C_POP_RD: begin
        stk_re = 1'b1; stk_ra = top_m1[SW-1:0];
      end
      C_STK_RD_CNT: begin
        stk_re = 1'b1; stk_ra = cnt_q[SW-1:0];
      end
      C_REC_RD_STK: begin
        rec_re = 1'b1; rec_ra = stk_rec_rd_q;
      end
      C_REC_RD_CNT: begin
        rec_re = 1'b1; rec_ra = cnt_q[CW-1:0];
      end
      C_REC_RD_IDX: begin
        rec_re = 1'b1; rec_ra = idx9[CW-1:0];
      end
      C_REC_ADD_WR: begin
        rec_we = 1'b1;
        rec_wd.sum = add48(rec_rd_q.sum, now_q, stk_start_rd_q);
      end
      C_CB_NEW: begin
        rec_we = 1'b1; rec_wa = fill9[CW-1:0];
        rec_wd.pc = pc_q; rec_wd.calls = 32'd1; rec_wd.sum = '0;
        push = 1'b1; push_idx = fill9[CW-1:0];
      end
      C_CB_HIT: begin
        rec_we = 1'b1; rec_wa = cnt_q[CW-1:0];
        rec_wd.calls = inc32(rec_rd_q.calls);
        push = 1'b1; push_idx = cnt_q[CW-1:0];
      end
      C_STK_START_WR: begin
        stk_start_we = 1'b1; stk_wa = cnt_q[SW-1:0];
      end
      default: ;
    endcase
    stk_we = push && !top_full;
    if (stk_we) stk_start_we = 1'b1;
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (rg_we) rg_mem[rg_addr_q] <= rg_wd;
    if (rg_re) begin
      rg_rd_q   <= rg_mem[rg_ra];
      rg_addr_q <= rg_ra;
    end
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) begin
      rec_rd_q   <= rec_mem[rec_ra];
      rec_addr_q <= rec_ra;
    end
    if (stk_we) stk_rec_mem[stk_wa] <= push_idx;
    if (stk_start_we) stk_start_mem[stk_wa] <= stk_wstart;
    if (stk_re) begin
      stk_rec_rd_q   <= stk_rec_mem[stk_ra];
      stk_start_rd_q <= stk_start_mem[stk_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rg_rvld_q <= 1'b0;
    end else if (rg_re) begin
      rg_rvld_q <= rg_vld_q[rg_ra] || (rg_we && rg_addr_q == rg_ra);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      act_start_q <= '0;
      act_sum_q   <= '0;
      rg_vld_q    <= '0;
      fill_q      <= '0;
      top_q       <= '0;
      drops_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rg_we) rg_vld_q[rg_addr_q] <= 1'b1;
      if (stk_we) top_q <= top_q + TW'(1);
      if (push && top_full) drops_q <= inc32(drops_q);
      // a load in the same cycle refills the register
      if (accept_out && cmd_i.op != C_OUT_LOAD) out_valid_q <= 1'b0;
      case (cmd_i.op)
        C_CAP:          cnt_q <= '0;
        C_CNT_INC,
        C_REC_ADD_WR,
        C_STK_START_WR: cnt_q <= cnt_q + CNT_W'(1);
        C_RG_SUM_WR,
        C_RG_START_WR:  cnt_q <= sts_o.rg_last ? '0 : cnt_q + CNT_W'(1);
        C_POP_RD:       top_q <= top_q - TW'(1);
        C_CB_DROP:      drops_q <= inc32(drops_q);
        C_CB_NEW:       fill_q <= fill_q + FW'(1);
        C_PAUSE_ACT:    act_sum_q <= add48(act_sum_q, now_q, act_start_q);
        C_PAUSE_END:    running_q <= 1'b0;
        C_RESUME_ACT: begin
          act_start_q <= now_q;
          running_q   <= 1'b1;
        end
        C_CLEAR: begin
          running_q   <= 1'b0;
          act_start_q <= '0;
          act_sum_q   <= '0;
          rg_vld_q    <= '0;
          fill_q      <= '0;
          top_q       <= '0;
          drops_q     <= '0;
        end
        C_OUT_LOAD:     out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // item latch and result fields
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      C_CAP: begin
        act_q  <= act_e'(action_i);
        id_q   <= region_id_i;
        exit_q <= is_exit_i;
        pc_q   <= call_pc_i;
        now_q  <= now_ticks_i;
        idx_q  <= read_index_i;
        res_status_q <= STS_DONE;
        res_idx_q    <= '0;
        res_calls_q  <= '0;
        res_depth_q  <= '0;
        res_unm_q    <= '0;
        res_sum_q    <= '0;
        res_pc_q     <= '0;
      end
      C_FIN_IGN: res_status_q <= STS_IGN;
      C_STAMP_WR: begin
        if (exit_q && rg_e.depth == 16'd0) res_status_q <= STS_UNM;
      end
      C_CB_DROP: res_status_q <= STS_DROP;
      C_CB_NEW, C_CB_HIT: begin
        res_idx_q <= 5'(push_idx);
        if (top_full) res_status_q <= STS_DROP;
      end
      C_RES_REGION: begin
        res_calls_q <= rg_e.calls;
        res_depth_q <= rg_e.depth;
        res_unm_q   <= rg_e.unm;
        res_sum_q   <= rg_e.sum;
      end
      C_RES_RECORD: begin
        res_calls_q <= rec_rd_q.calls;
        res_sum_q   <= rec_rd_q.sum;
        res_pc_q    <= rec_rd_q.pc;
      end
      C_RES_TOTALS: begin
        res_depth_q <= 16'(top_q);
        res_sum_q   <= act_sum_q;
      end
      C_OUT_LOAD: begin
        status_o          <= res_status_q;
        record_index_o    <= res_idx_q;
        call_count_o      <= res_calls_q;
        open_depth_o      <= res_depth_q;
        unmatched_count_o <= res_unm_q;
        total_ticks_o     <= res_sum_q;
        record_pc_o       <= res_pc_q;
        records_used_o    <= 6'(fill_q);
        drop_count_o      <= drops_q;
        is_running_o      <= running_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/nrp_checker.sv]
// Port-level checks of the profiler, bound to the top level.
`include "nested_region_profiler_macros.svh"

module nrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  action_i,
  input logic [7:0]  region_id_i,
  input logic        is_exit_i,
  input logic [31:0] call_pc_i,
  input logic [31:0] now_ticks_i,
  input logic [4:0]  read_index_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [4:0]  record_index_o,
  input logic [31:0] call_count_o,
  input logic [15:0] open_depth_o,
  input logic [31:0] unmatched_count_o,
  input logic [47:0] total_ticks_o,
  input logic [31:0] record_pc_o,
  input logic [5:0]  records_used_o,
  input logic [31:0] drop_count_o,
  input logic        is_running_o
);
  import nrp_pkg::*;

  `NRP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `NRP_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "second item taken while busy")
  `NRP_ASSERT_IMP(a_drop_running, out_valid_o && (status_o == STS_DROP || status_o == STS_UNM), is_running_o, "drop or unmatched exit while paused")
  `NRP_ASSERT_IMP(a_drop_counted, out_valid_o && status_o == STS_DROP, drop_count_o != 32'd0, "drop status with zero drop count")

endmodule

bind nested_region_profiler nrp_checker u_nrp_checker (.*);

[dv/testbench.sv]
// Self-checking testbench for the nested region profiler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nrp_pkg::*;

  localparam int NREG = NUM_REGIONS_DEF;
  localparam int NREC = NUM_RECORDS_DEF;
  localparam int NSTK = STACK_DEPTH_DEF;
  localparam int CBREG = CALLBACK_REGION_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  rec_idx;
    logic [31:0] calls;
    logic [15:0] depth;
    logic [31:0] unm;
    logic [47:0] ticks;
    logic [31:0] pc;
    logic [5:0]  used;
    logic [31:0] drops;
    logic        running;
  } prof_res_t;

  typedef struct packed {
    act_e        act;
    logic [7:0]  id;
    logic        ex;
    logic [31:0] pc;
    logic [31:0] now;
    logic [4:0]  idx;
  } prof_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] action_i = '0;
  logic [7:0] region_id_i = '0;
  logic is_exit_i = 1'b0;
  logic [31:0] call_pc_i = '0;
  logic [31:0] now_ticks_i = '0;
  logic [4:0] read_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [4:0] record_index_o;
  logic [31:0] call_count_o;
  logic [15:0] open_depth_o;
  logic [31:0] unmatched_count_o;
  logic [47:0] total_ticks_o;
  logic [31:0] record_pc_o;
  logic [5:0] records_used_o;
  logic [31:0] drop_count_o;
  logic is_running_o;

  nested_region_profiler DUT (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic        p_run;
  logic [31:0] p_act_start;
  logic [47:0] p_act_sum;
  logic [31:0] p_rg_calls[NREG];
  logic [15:0] p_rg_depth[NREG];
  logic [31:0] p_rg_start[NREG];
  logic [47:0] p_rg_sum[NREG];
  logic [31:0] p_rg_unm[NREG];
  logic [31:0] p_rec_pc[NREC];
  logic [31:0] p_rec_calls[NREC];
  logic [47:0] p_rec_sum[NREC];
  int          p_fill;
  logic [4:0]  p_stk_rec[NSTK];
  logic [31:0] p_stk_start[NSTK];
  int          p_top;
  logic [31:0] p_drops;

  prof_res_t expected_q[$];
  int errors = 0;
  logic [31:0] clock_now = 32'd1000;
  logic [31:0] pc_pool[40];

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sum_elapsed(logic [47:0] s, logic [31:0] now,
                                              logic [31:0] st);
    logic [48:0] t;
    t = {1'b0, s} + {17'd0, 32'(now - st)};
    return t[48] ? '1 : t[47:0];
  endfunction

  function automatic void clear_profile();
    p_run = 1'b0; p_act_start = '0; p_act_sum = '0; p_fill = 0; p_top = 0; p_drops = '0;
    for (int i = 0; i < NREG; i++) begin
      p_rg_calls[i] = '0; p_rg_depth[i] = '0; p_rg_start[i] = '0;
      p_rg_sum[i] = '0; p_rg_unm[i] = '0;
    end
    for (int i = 0; i < NREC; i++) begin
      p_rec_calls[i] = '0; p_rec_sum[i] = '0;
    end
  endfunction

  function automatic void enter_region(int id, logic [31:0] now);
    p_rg_calls[id] = sat_inc(p_rg_calls[id]);
    if (p_rg_depth[id] == 0) p_rg_start[id] = now;
    if (p_rg_depth[id] != 16'hFFFF) p_rg_depth[id]++;
  endfunction

  function automatic prof_res_t profile_step(prof_item_t it);
    prof_res_t r;
    int i;
    r = '0;
    case (it.act)
      ACT_STAMP: begin
        if (!p_run || it.id == 0 || it.id >= NREG) r.status = STS_IGN;
        else if (!it.ex) enter_region(it.id, it.now);
        else if (p_rg_depth[it.id] == 0) begin
          p_rg_unm[it.id] = sat_inc(p_rg_unm[it.id]);
          r.status = STS_UNM;
        end else begin
          p_rg_depth[it.id]--;
          if (p_rg_depth[it.id] == 0)
            p_rg_sum[it.id] = sum_elapsed(p_rg_sum[it.id], it.now, p_rg_start[it.id]);
          if (it.id == CBREG && p_top > 0) begin
            p_top--;
            p_rec_sum[p_stk_rec[p_top]] = sum_elapsed(p_rec_sum[p_stk_rec[p_top]],
                                                      it.now, p_stk_start[p_top]);
          end
        end
      end
      ACT_CALLBACK: begin
        if (!p_run) r.status = STS_IGN;
        else begin
          enter_region(CBREG, it.now);
          for (i = 0; i < p_fill; i++) if (p_rec_pc[i] == it.pc) break;
          if (i >= p_fill && p_fill >= NREC) begin
            p_drops = sat_inc(p_drops);
            r.status = STS_DROP;
          end else begin
            if (i >= p_fill) begin
              p_rec_pc[i] = it.pc;
              p_fill++;
            end
            p_rec_calls[i] = sat_inc(p_rec_calls[i]);
            r.rec_idx = 5'(i);
            if (p_top < NSTK) begin
              p_stk_rec[p_top] = 5'(i); p_stk_start[p_top] = it.now; p_top++;
            end else begin
              p_drops = sat_inc(p_drops);
              r.status = STS_DROP;
            end
          end
        end
      end
      ACT_PAUSE: begin
        if (!p_run) r.status = STS_IGN;
        else begin
          p_act_sum = sum_elapsed(p_act_sum, it.now, p_act_start);
          for (i = 1; i < NREG; i++)
            if (p_rg_depth[i] != 0)
              p_rg_sum[i] = sum_elapsed(p_rg_sum[i], it.now, p_rg_start[i]);
          for (i = 0; i < p_top; i++)
            p_rec_sum[p_stk_rec[i]] = sum_elapsed(p_rec_sum[p_stk_rec[i]], it.now,
                                                  p_stk_start[i]);
          p_run = 1'b0;
        end
      end
      ACT_RESUME: begin
        if (p_run) r.status = STS_IGN;
        else begin
          p_act_start = it.now; p_run = 1'b1;
          for (i = 1; i < NREG; i++) if (p_rg_depth[i] != 0) p_rg_start[i] = it.now;
          for (i = 0; i < p_top; i++) p_stk_start[i] = it.now;
        end
      end
      ACT_CLEAR: clear_profile();
      ACT_RD_REGION: begin
        if (it.idx == 0 || it.idx >= NREG) r.status = STS_IGN;
        else begin
          r.calls = p_rg_calls[it.idx]; r.depth = p_rg_depth[it.idx];
          r.unm = p_rg_unm[it.idx]; r.ticks = p_rg_sum[it.idx];
        end
      end
      ACT_RD_RECORD: begin
        if (it.idx >= p_fill) r.status = STS_IGN;
        else begin
          r.calls = p_rec_calls[it.idx]; r.ticks = p_rec_sum[it.idx];
          r.pc = p_rec_pc[it.idx];
        end
      end
      default: begin
        r.depth = 16'(p_top); r.ticks = p_act_sum;
      end
    endcase
    r.used = 6'(p_fill); r.drops = p_drops; r.running = p_run;
    return r;
  endfunction

  // idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int idle_mode = 0;

  always @(posedge clk_i) begin
    out_stall_i <= (idle_mode == 2 && $urandom_range(99) < 69) ||
                   (idle_mode == 3 && $urandom_range(99) < 22);
  end

  // valid stays up between back-to-back items; it drops only while idling or draining
  task automatic send_item(prof_item_t it, logic check_known, prof_res_t known);
    prof_res_t r;
    while ((idle_mode == 1 && $urandom_range(99) < 69) ||
           (idle_mode == 3 && $urandom_range(99) < 22)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    action_i <= it.act; region_id_i <= it.id; is_exit_i <= it.ex;
    call_pc_i <= it.pc; now_ticks_i <= it.now; read_index_i <= it.idx;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = profile_step(it);
    if (check_known && r != known) begin
      $error("directed row: result exp %h got %h", known, r);
      errors++;
    end
    expected_q.push_back(check_known ? known : r);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  always @(posedge clk_i) begin
    prof_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with none expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++; end
        if (record_index_o !== e.rec_idx) begin
          $error("record_index exp %0d got %0d", e.rec_idx, record_index_o); errors++; end
        if (call_count_o !== e.calls) begin
          $error("call_count exp %0d got %0d", e.calls, call_count_o); errors++; end
        if (open_depth_o !== e.depth) begin
          $error("open_depth exp %0d got %0d", e.depth, open_depth_o); errors++; end
        if (unmatched_count_o !== e.unm) begin
          $error("unmatched_count exp %0d got %0d", e.unm, unmatched_count_o); errors++; end
        if (total_ticks_o !== e.ticks) begin
          $error("total_ticks exp %0d got %0d", e.ticks, total_ticks_o); errors++; end
        if (record_pc_o !== e.pc) begin
          $error("record_pc exp %h got %h", e.pc, record_pc_o); errors++; end
        if (records_used_o !== e.used) begin
          $error("records_used exp %0d got %0d", e.used, records_used_o); errors++; end
        if (drop_count_o !== e.drops) begin
          $error("drop_count exp %0d got %0d", e.drops, drop_count_o); errors++; end
        if (is_running_o !== e.running) begin
          $error("is_running exp %0d got %0d", e.running, is_running_o); errors++; end
      end
    end
  end

  function automatic prof_item_t mk(act_e a, int id, bit ex, logic [31:0] pc,
                                    logic [31:0] now, int idx);
    prof_item_t it;
    it.act = a; it.id = 8'(id); it.ex = ex; it.pc = pc; it.now = now; it.idx = 5'(idx);
    return it;
  endfunction

  function automatic prof_res_t known_res(logic [1:0] st, logic run);
    prof_res_t r;
    r = '0; r.status = st; r.running = run;
    return r;
  endfunction

  // weighted random item; mostly well-formed activity while running
  function automatic prof_item_t rand_item(int wide_pc);
    prof_item_t it;
    int k;
    k = $urandom_range(99);
    it = '0;
    it.now = $urandom_range(5) == 0 ? $urandom : clock_now;
    it.pc = wide_pc ? $urandom : pc_pool[$urandom_range(wide_pc ? 39 : 9)];
    it.idx = 5'($urandom);
    it.id = $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(1, NREG - 1));
    it.ex = 1'($urandom);
    if (k < 50) it.act = ACT_STAMP;
    else if (k < 68) begin
      it.act = ACT_STAMP; it.id = 8'(CBREG); it.ex = 1'b1;
    end
    else if (k < 80) it.act = ACT_CALLBACK;
    else if (k < 83) it.act = ACT_PAUSE;
    else if (k < 87) it.act = ACT_RESUME;
    else if (k < 88) it.act = ACT_CLEAR;
    else if (k < 93) it.act = ACT_RD_REGION;
    else if (k < 97) it.act = ACT_RD_RECORD;
    else it.act = ACT_RD_TOTALS;
    return it;
  endfunction

  prof_item_t dir_rows[$];
  logic       dir_known[$];
  prof_res_t  dir_res[$];

  initial begin
    prof_res_t r;
    clear_profile();
    for (int i = 0; i < 40; i++) pc_pool[i] = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: known results after reset, then predictor-checked rows
    dir_rows.push_back(mk(ACT_STAMP, 1, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 0));
    dir_rows.push_back(mk(ACT_CALLBACK, 0, 0, 32'hFFFF_FFFF, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 0));
    dir_rows.push_back(mk(ACT_PAUSE, 0, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 0));
    dir_rows.push_back(mk(ACT_RD_REGION, 0, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 0));
    dir_rows.push_back(mk(ACT_RD_RECORD, 0, 0, 0, 0, 31));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 0));
    dir_rows.push_back(mk(ACT_RESUME, 0, 0, 0, 32'hFFFF_FFF0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_DONE, 1));
    dir_rows.push_back(mk(ACT_RESUME, 0, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 1));
    dir_rows.push_back(mk(ACT_STAMP, 0, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 1));
    dir_rows.push_back(mk(ACT_STAMP, 255, 1, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 1));
    dir_rows.push_back(mk(ACT_STAMP, 7, 0, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_IGN, 1));
    dir_rows.push_back(mk(ACT_STAMP, 6, 1, 0, 0, 0));
    dir_known.push_back(1); dir_res.push_back(known_res(STS_UNM, 1));
    // wrap of the tick counter across an outer region, then callbacks, pause, resume, reads, clear
    dir_rows.push_back(mk(ACT_STAMP, 1, 0, 0, 32'hFFFF_FFF8, 0));
    dir_rows.push_back(mk(ACT_STAMP, 1, 0, 0, 32'h4, 0));
    dir_rows.push_back(mk(ACT_STAMP, 1, 1, 0, 32'h10, 0));
    dir_rows.push_back(mk(ACT_STAMP, 1, 1, 0, 32'h20, 0));
    dir_rows.push_back(mk(ACT_CALLBACK, 0, 0, 32'h0, 32'h30, 0));
    dir_rows.push_back(mk(ACT_CALLBACK, 0, 0, 32'hFFFF_FFFF, 32'h40, 0));
    dir_rows.push_back(mk(ACT_CALLBACK, 0, 0, 32'h0, 32'h50, 0));
    dir_rows.push_back(mk(ACT_PAUSE, 0, 0, 0, 32'h90, 0));
    dir_rows.push_back(mk(ACT_RESUME, 0, 0, 0, 32'h100, 0));
    dir_rows.push_back(mk(ACT_STAMP, 5, 1, 0, 32'h120, 0));
    dir_rows.push_back(mk(ACT_RD_RECORD, 0, 0, 0, 0, 1));
    dir_rows.push_back(mk(ACT_RD_REGION, 0, 0, 0, 0, 5));
    dir_rows.push_back(mk(ACT_RD_TOTALS, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) begin
      r = (i < dir_known.size()) ? dir_res[i] : '0;
      send_item(dir_rows[i], i < dir_known.size(), r);
    end

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      send_item(mk(ACT_RESUME, 0, 0, 0, clock_now, 0), 0, '0);
      for (int n = 0; n < 170; n++) begin
        clock_now += $urandom_range(ph == 5 ? 32'h7FFF_FFFF : 300);
        // phase 6 feeds the record table fresh random pcs
        send_item(rand_item(ph == 6), 0, '0);
        if (!p_run && $urandom_range(3) == 0)
          send_item(mk(ACT_RESUME, 0, 0, 0, clock_now, 0), 0, '0);
      end
      // hold off until every result is back
      drain_results();
      if (ph == 3) send_item(mk(ACT_CLEAR, 0, 0, 0, 0, 0), 0, '0);
    end
    for (int i = 0; i < NREC; i++)
      send_item(mk(ACT_RD_RECORD, 0, 0, 0, 0, i), 0, '0);

    idle_mode = 0;
    drain_results();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

[nested_region_profiler.f]
+incdir+design
design/nrp_pkg.sv
design/nrp_ctrl.sv
design/nrp_dpath.sv
design/nested_region_profiler.sv
design/nrp_checker.sv
dv/testbench.sv
